### hdl/nars_pkg.sv
// ----------------------------------------------------------------------------
// nars_pkg
// Shared constants, types and the arctangent table of the angular
// resolution score block.
// ----------------------------------------------------------------------------
package nars_pkg;

   localparam int MaxDegree   = 16;
   localparam int CordicSteps = 16;
   localparam int AngW        = 16;
   localparam int IdxW        = $clog2(MaxDegree);
   localparam int CntW        = $clog2(MaxDegree + 1);
   localparam int StepW       = $clog2(CordicSteps + 1);
   localparam int VecW        = 28;  // 17-bit difference times 256, plus gain headroom
   localparam logic [16:0] FullTurn = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_WRITE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_GAP,
      ST_SCORE,
      ST_OUT
   } state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] t;
      case (i)
         5'd0:  t = 32'h20000000;
         5'd1:  t = 32'h12E4051E;
         5'd2:  t = 32'h09FB385B;
         5'd3:  t = 32'h051111D4;
         5'd4:  t = 32'h028B0D43;
         5'd5:  t = 32'h0145D7E1;
         5'd6:  t = 32'h00A2F61E;
         5'd7:  t = 32'h00517C55;
         5'd8:  t = 32'h0028BE53;
         5'd9:  t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98;
         5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6;
         5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA;
         5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE;
         5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30;
         5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C;
         5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3;
         5'd23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

endpackage

### hdl/node_angular_resolution_score.sv
// ----------------------------------------------------------------------------
// node_angular_resolution_score
// Angular resolution score of one node from its neighbor positions.
// ----------------------------------------------------------------------------
// Sequence: a stored neighbor runs the CORDIC setup, 16 CORDIC steps and the
//   write; a dropped neighbor beyond the store only sets the overflow flag.
// The last neighbor adds a memory read and an insertion scan per stored angle,
//   then the gap pass and the score.
// Throughput: one request at a time, taken only while the sequencer is idle.
// Reset: synchronous; clears the count, overflow flag and sequencer.
module node_angular_resolution_score (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_center_x,
   input  logic signed [15:0]  req_center_y,
   input  logic signed [15:0]  req_neighbor_x,
   input  logic signed [15:0]  req_neighbor_y,
   input  logic                req_last_neighbor,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [16:0]         rsp_score,
   output logic [4:0]          rsp_degree_seen,
   output logic                rsp_overflow
);

   // Sequencer owns the angle memory and the CORDIC unit.
   nars_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_neighbor_x(req_neighbor_x), .req_neighbor_y(req_neighbor_y),
      .req_last_neighbor(req_last_neighbor),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_score(rsp_score), .rsp_degree_seen(rsp_degree_seen),
      .rsp_overflow(rsp_overflow)
   );

endmodule

### hdl/nars_ram.sv
// ----------------------------------------------------------------------------
// nars_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nars_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

### hdl/nars_cordic.sv
// ----------------------------------------------------------------------------
// nars_cordic
// Iterative vectoring CORDIC: one rotation step per cycle, binary angle out.
// ----------------------------------------------------------------------------
module nars_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [16:0]  dx,
   input  logic signed [16:0]  dy,
   output logic                done,
   output logic [nars_pkg::AngW-1:0] angle
);

   logic signed [nars_pkg::VecW-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]                      z_ff, z_in;
   logic [nars_pkg::StepW-1:0]       step_ff, step_in;
   logic                             busy_ff, busy_in;
   logic                             zero_ff, zero_in;
   logic signed [nars_pkg::VecW-1:0] xs, ys, x0, y0;
   logic [31:0]                      zr;

   always_comb begin
      x0 = {{(nars_pkg::VecW-25){dx[16]}}, dx, 8'h00};
      y0 = {{(nars_pkg::VecW-25){dy[16]}}, dy, 8'h00};
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; busy_in = busy_ff; zero_in = zero_ff;
      if (start) begin
         zero_in = (dx == 17'sd0) && (dy == 17'sd0);
         busy_in = 1'b1;
         step_in = '0;
         if (dx[16]) begin
            x_in = -x0; y_in = -y0; z_in = 32'h80000000;
         end else begin
            x_in = x0; y_in = y0; z_in = 32'h0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs;
            z_in = z_ff + nars_pkg::atan_turn(5'(step_ff));
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs;
            z_in = z_ff - nars_pkg::atan_turn(5'(step_ff));
         end
         step_in = step_ff + 1'b1;
         if (step_ff == nars_pkg::StepW'(nars_pkg::CordicSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; zero_ff <= zero_in;
   end

   assign zr    = z_ff + 32'h00008000;
   assign done  = ~busy_ff;
   assign angle = zero_ff ? '0 : zr[31:16];

endmodule

### hdl/nars_ctrl.sv
// ----------------------------------------------------------------------------
// nars_ctrl
// Sequencer: store angles, then on the last neighbor run an insertion scan
// over the angle memory, find the smallest gap and form the score.
// ----------------------------------------------------------------------------
module nars_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_center_x,
   input  logic signed [15:0]  req_center_y,
   input  logic signed [15:0]  req_neighbor_x,
   input  logic signed [15:0]  req_neighbor_y,
   input  logic                req_last_neighbor,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [16:0]         rsp_score,
   output logic [4:0]          rsp_degree_seen,
   output logic                rsp_overflow
);

   localparam int N = nars_pkg::MaxDegree;

   nars_pkg::state_type state_ff, state_in;
   logic [nars_pkg::CntW-1:0] count_ff, count_in;
   logic                      ovf_ff, ovf_in, last_ff, last_in;
   logic [nars_pkg::CntW-1:0] idx_ff, idx_in;
   logic [15:0]               srt_ff [N];
   logic [15:0]               srt_in [N];
   logic [nars_pkg::CntW-1:0] gi_ff, gi_in;
   logic [16:0]               gap_ff, gap_in;
   logic [16:0]               score_ff, score_in;
   logic [4:0]                deg_ff, deg_in;
   logic                      oflag_ff, oflag_in;
   logic                      cstart, cdone;
   logic [15:0]               cangle, rd_data;
   logic signed [16:0]        dx, dy;
   logic                      wr_en;
   logic [16:0]               g;
   logic [21:0]               prod;
   logic [15:0]               a;
   logic                      ins;

   assign dx = 17'(req_neighbor_x) - 17'(req_center_x);
   assign dy = 17'(req_neighbor_y) - 17'(req_center_y);

   nars_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cstart),
      .dx(dx), .dy(dy), .done(cdone), .angle(cangle)
   );

   nars_ram #(.Width(16), .Depth(N)) u_ram (
      .clock(clock), .wr_en(wr_en),
      .wr_addr(count_ff[nars_pkg::IdxW-1:0]), .wr_data(cangle),
      .rd_addr(idx_ff[nars_pkg::IdxW-1:0]), .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff; count_in = count_ff; ovf_in = ovf_ff; last_in = last_ff;
      idx_in = idx_ff; gi_in = gi_ff; gap_in = gap_ff; score_in = score_ff;
      deg_in = deg_ff; oflag_in = oflag_ff;
      for (int k = 0; k < N; k++) srt_in[k] = srt_ff[k];
      cstart = 1'b0; wr_en = 1'b0;
      req_stall = (state_ff != nars_pkg::ST_IDLE);
      a = rd_data;
      g = '0; prod = '0; ins = 1'b0;
      case (state_ff)
         nars_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last_neighbor;
               if (count_ff < nars_pkg::CntW'(N)) begin
                  cstart = 1'b1;
                  state_in = nars_pkg::ST_CORDIC;
               end else begin
                  ovf_in = 1'b1;
                  state_in = req_last_neighbor ? nars_pkg::ST_SCAN_RD : nars_pkg::ST_IDLE;
                  idx_in = '0;
               end
            end
         end
         nars_pkg::ST_CORDIC: begin
            if (cdone) state_in = nars_pkg::ST_WRITE;
         end
         nars_pkg::ST_WRITE: begin
            // write the angle from the CORDIC unit at the current count
            wr_en = 1'b1;
            count_in = count_ff + 1'b1;
            idx_in = '0;
            state_in = last_ff ? nars_pkg::ST_SCAN_RD : nars_pkg::ST_IDLE;
         end
         nars_pkg::ST_SCAN_RD: begin
            state_in = nars_pkg::ST_SCAN;
         end
         nars_pkg::ST_SCAN: begin
            // insert rd_data into sorted prefix of length idx_ff
            for (int k = N - 1; k >= 0; k--) begin
               if (k < 32'(idx_ff)) begin
                  if (srt_ff[k] > a) srt_in[k+1 < N ? k+1 : k] = srt_ff[k];
               end
            end
            for (int k = 0; k < N; k++) begin
               if (k <= 32'(idx_ff)) begin
                  ins = (k == 0) ? 1'b1 : !(srt_ff[k-1 > 0 ? k-1 : 0] > a);
                  if (ins && (k == 32'(idx_ff) || srt_ff[k] > a)) srt_in[k] = a;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_in == count_ff) begin
               state_in = nars_pkg::ST_GAP;
               gi_in = nars_pkg::CntW'(1);
               gap_in = 17'(srt_in[0]) + nars_pkg::FullTurn
                        - 17'(srt_in[nars_pkg::IdxW'(count_ff - 1'b1)]);
            end else begin
               state_in = nars_pkg::ST_SCAN_RD;
            end
         end
         nars_pkg::ST_GAP: begin
            if (gi_ff >= count_ff) begin
               state_in = nars_pkg::ST_SCORE;
            end else begin
               g = 17'(srt_ff[nars_pkg::IdxW'(gi_ff)])
                   - 17'(srt_ff[nars_pkg::IdxW'(gi_ff - 1'b1)]);
               if (g < gap_ff) gap_in = g;
               gi_in = gi_ff + 1'b1;
            end
         end
         nars_pkg::ST_SCORE: begin
            prod = 22'(gap_ff) * 22'(count_ff);
            score_in = (prod >= 22'(nars_pkg::FullTurn)) ? 17'd0
                       : nars_pkg::FullTurn - prod[16:0];
            deg_in = 5'(count_ff);
            oflag_in = ovf_ff;
            count_in = '0; ovf_in = 1'b0;
            state_in = nars_pkg::ST_OUT;
         end
         nars_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = nars_pkg::ST_IDLE;
         end
         default: state_in = nars_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nars_pkg::ST_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
      last_ff <= last_in; idx_ff <= idx_in; gi_ff <= gi_in; gap_ff <= gap_in;
      score_ff <= score_in; deg_ff <= deg_in; oflag_ff <= oflag_in;
      for (int k = 0; k < N; k++) srt_ff[k] <= srt_in[k];
   end

   assign rsp_valid       = (state_ff == nars_pkg::ST_OUT);
   assign rsp_score       = score_ff;
   assign rsp_degree_seen = deg_ff;
   assign rsp_overflow    = oflag_ff;

endmodule

### hdl/nars_checker.sv
// ----------------------------------------------------------------------------
// nars_checker
// Port-level checks of the angular resolution score block.
// ----------------------------------------------------------------------------
module nars_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_score,
   input logic [4:0]  rsp_degree_seen
);

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score <= 17'h10000) else $error("score out of range");

   a_degree_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_degree_seen != 5'd0 && rsp_degree_seen <= 5'd16))
      else $error("degree out of range");

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score))
      else $error("stalled result changed");

endmodule

bind node_angular_resolution_score nars_checker u_nars_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_score(rsp_score),
   .rsp_degree_seen(rsp_degree_seen)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed neighbor sets into the angular resolution score
// block and checks every score against a bit-exact CORDIC and gap predictor.
// ----------------------------------------------------------------------------

class score_board;
   logic [16:0] exp_score[$];
   logic [4:0]  exp_degree[$];
   logic        exp_ovf[$];
   logic [15:0] angles[16];
   int unsigned count;
   bit          ovf_seen;
   int          errors;

   function new();
      count = 0;
      ovf_seen = 0;
      errors = 0;
   endfunction

   static function logic [15:0] angle_of(int signed dx, int signed dy);
      longint signed x, y, xs, ys;
      logic [31:0] z;
      logic [31:0] t;
      x = longint'(dx) * 256;
      y = longint'(dy) * 256;
      z = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h80000000;
      end
      for (int i = 0; i < nars_pkg::CordicSteps; i++) begin
         t = nars_pkg::atan_turn(i[4:0]);
         ys = y >>> i;  // arithmetic shift is floor
         xs = x >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + t;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - t;
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   // Note one accepted request; returns 1 when it closes a set.
   function bit note_request(logic signed [15:0] cx, logic signed [15:0] cy,
                             logic signed [15:0] nx, logic signed [15:0] ny,
                             logic last);
      logic [15:0] srt[16];
      logic [15:0] a;
      int unsigned j, min_gap, g, prod, sc;
      if (count < 16) begin
         angles[count] = angle_of(int'(nx) - int'(cx), int'(ny) - int'(cy));
         count++;
      end else ovf_seen = 1;
      if (!last) return 0;
      for (int i = 0; i < count; i++) begin
         a = angles[i];
         j = i;
         while (j > 0 && srt[j-1] > a) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = a;
      end
      min_gap = 65536;
      for (int i = 1; i < count; i++) begin
         g = srt[i] - srt[i-1];
         if (g < min_gap) min_gap = g;
      end
      g = srt[0] + 65536 - srt[count-1];
      if (g < min_gap) min_gap = g;
      prod = min_gap * count;
      sc = (prod >= 65536) ? 0 : 65536 - prod;
      exp_score.push_back(sc[16:0]);
      exp_degree.push_back(count[4:0]);
      exp_ovf.push_back(ovf_seen);
      count = 0;
      ovf_seen = 0;
      return 1;
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_result(logic [16:0] sc, logic [4:0] dg, logic ov);
      if (exp_score.size() == 0) begin
         report("unexpected result", sc, -1);
         return;
      end
      if (sc !== exp_score[0]) report("score", sc, exp_score[0]);
      if (dg !== exp_degree[0]) report("degree_seen", dg, exp_degree[0]);
      if (ov !== exp_ovf[0]) report("overflow", ov, exp_ovf[0]);
      void'(exp_score.pop_front());
      void'(exp_degree.pop_front());
      void'(exp_ovf.pop_front());
   endtask
endclass

module testbench;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_center_x = 0, req_center_y = 0;
   logic signed [15:0] req_neighbor_x = 0, req_neighbor_y = 0;
   logic req_last_neighbor = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [16:0] rsp_score;
   logic [4:0] rsp_degree_seen;
   logic rsp_overflow;

   score_board sb = new();
   bit long_hold = 0;     // receiver holds off for a long stretch
   int idle_cycles = 0;

   node_angular_resolution_score DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: random stall per result, plus one long hold-off counted here.
   initial begin
      int w;
      repeat (7) @(posedge clock);
      reset <= 0;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         w = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) w = 0;
         rsp_stall <= (w != 0);
         repeat (w) @(posedge clock);
         rsp_stall <= 0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall) && !long_hold) @(posedge clock);
      end
   end

   // Check on each accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_score, rsp_degree_seen, rsp_overflow);
   end

   // Watchdog: cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("node_angular_resolution_score test failed");
         $finish;
      end
   end

   // Offer one request, after a random gap when gaps is set; hold it until accepted.
   task send(logic signed [15:0] cx, logic signed [15:0] cy,
             logic signed [15:0] nx, logic signed [15:0] ny, logic last,
             bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 6) : 0;
      if (w != 0) begin
         req_valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1;
      req_center_x <= cx;
      req_center_y <= cy;
      req_neighbor_x <= nx;
      req_neighbor_y <= ny;
      req_last_neighbor <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_request(cx, cy, nx, ny, last));
   endtask

   task drain();
      req_valid <= 0;
      while (sb.exp_score.size() != 0) @(posedge clock);
   endtask

   // Random set of n neighbors, mostly around one center; small coordinates often.
   task random_set(int n, bit gaps);
      logic signed [15:0] cx, cy, nx, ny;
      int mode;
      mode = $urandom_range(0, 3);
      cx = 16'($urandom);
      cy = 16'($urandom);
      if (mode == 0) begin
         cx = 16'($signed($urandom_range(0, 200)) - 100);
         cy = 16'($signed($urandom_range(0, 200)) - 100);
      end
      for (int i = 0; i < n; i++) begin
         nx = 16'($urandom);
         ny = 16'($urandom);
         if (mode == 0) begin
            nx = 16'(int'(cx) + $signed($urandom_range(0, 40)) - 20);
            ny = 16'(int'(cy) + $signed($urandom_range(0, 40)) - 20);
         end
         if (mode == 1 && $urandom_range(0, 7) == 0) begin
            cx = 16'($urandom);   // center changes inside a set
            cy = 16'($urandom);
         end
         send(cx, cy, nx, ny, i == n - 1, gaps);
      end
   endtask

   initial begin
      int n, items;
      @(negedge reset);
      @(posedge clock);
      // Directed: single neighbor, coincident points, extremes.
      send(0, 0, 16'sd100, 0, 1, 0);
      send(16'sd5, 16'sd5, 16'sd5, 16'sd5, 1, 0);
      send(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, 0);
      send(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 0);
      send(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 0);
      send(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1, 0);
      // Equal angles.
      send(0, 0, 16'sd10, 16'sd10, 0, 0);
      send(0, 0, 16'sd20, 16'sd20, 1, 0);
      // Axes: +x, +y, -x (negative x with zero y), -y.
      send(0, 0, 16'sd1, 0, 0, 0);
      send(0, 0, 0, 16'sd1, 0, 0);
      send(0, 0, -16'sd1, 0, 0, 0);
      send(0, 0, 0, -16'sd1, 1, 0);
      // Overflow: 18 neighbors, the last two dropped; the last one still ends the set.
      for (int i = 0; i < 18; i++)
         send(0, 0, 16'(i * 37 - 300), 16'(i * i - 100), i == 17, 0);
      // Exactly MAX_DEGREE.
      random_set(16, 0);
      drain();

      // Long receiver hold-off while requests keep coming.
      long_hold = 1;
      random_set(2, 0);
      random_set(3, 0);
      drain();

      items = 0;
      while (items < 500) begin
         n = $urandom_range(1, 5);
         if ($urandom_range(0, 15) == 0) n = $urandom_range(6, 19);
         random_set(n, $urandom_range(0, 3) != 0);
         items += n;
         if ($urandom_range(0, 30) == 0) drain();
      end
      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.exp_score.size() == 0)
         $display("node_angular_resolution_score test passed");
      else
         $display("node_angular_resolution_score test failed");
      $finish;
   end
endmodule
